// ===== rtl/rational_arithmetic_unit_macros.svh =====
// Assertion macros for the rational arithmetic unit.
// Used by the top level only.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define RAU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Assert that an antecedent implies a consequent in the following cycle.
`define RAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] a_num;
      logic signed [15:0] a_den;
      logic signed [15:0] b_num;
      logic signed [15:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [29:0]        res_den;
      logic               invalid;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // capture request operands
      logic prod;     // register products
      logic sum;      // form raw fraction
      logic gcd_init; // start Euclid
      logic rem_step; // one restoring-division bit
      logic rem_init; // start a remainder pass
      logic gcd_swap; // x <= y, y <= remainder
      logic div_init; // start quotient passes
      logic div_step; // one quotient bit for both divisions
      logic finish;   // build result
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic special; // zero num or zero den
      logic y_zero;  // Euclid done
      logic last;    // final division bit
   } sts_type;
endpackage

// ===== rtl/rau_datapath.sv =====
// Datapath: cross products, sign handling, bit-serial Euclid and division.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_datapath (
   input  logic             clock,
   input  logic             reset,
   input  rau_pkg::req_type req,
   input  rau_pkg::cmd_type cmd,
   output rau_pkg::sts_type sts,
   output rau_pkg::rsp_type rsp
);
   rau_pkg::req_type   op_ff;
   logic signed [31:0] p0_ff, p1_ff, p2_ff;
   logic signed [32:0] n_ff;
   logic signed [31:0] d_ff;
   logic [32:0]        mn_ff, md_ff;
   logic               neg_ff;
   logic [32:0]        x_ff, y_ff;
   logic [32:0]        r_ff, q_ff;       // remainder and dividend shift reg
   logic [32:0]        rn_ff, qn_ff, rd_ff, qd_ff;
   logic [5:0]         cnt_ff;
   rau_pkg::rsp_type   rsp_ff;
   logic [33:0]        trial, trial_n, trial_d;
   logic signed [32:0] nsum;

   // Combine the products into the numerator per operation
   always_comb begin
      nsum = '0;
      unique case (op_ff.action)
         rau_pkg::OP_ADD: nsum = 33'(p0_ff) + 33'(p1_ff);
         rau_pkg::OP_SUB: nsum = 33'(p0_ff) - 33'(p1_ff);
         rau_pkg::OP_MUL: nsum = 33'(p0_ff);
         rau_pkg::OP_DIV: nsum = 33'(p0_ff);
         default:         nsum = '0;
      endcase
   end

   assign trial   = {r_ff, q_ff[32]} - {1'b0, y_ff};
   assign trial_n = {rn_ff, qn_ff[32]} - {1'b0, x_ff};
   assign trial_d = {rd_ff, qd_ff[32]} - {1'b0, x_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) op_ff <= req;
      // Register the products
      if (cmd.prod) begin
         unique case (op_ff.action)
            rau_pkg::OP_MUL: begin
               p0_ff <= op_ff.a_num * op_ff.b_num;
               p1_ff <= op_ff.b_num * op_ff.a_den;
            end
            default: begin
               p0_ff <= op_ff.a_num * op_ff.b_den;
               p1_ff <= op_ff.b_num * op_ff.a_den;
            end
         endcase
         if (op_ff.action == rau_pkg::OP_DIV) p2_ff <= op_ff.a_den * op_ff.b_num;
         else                                p2_ff <= op_ff.a_den * op_ff.b_den;
      end
      if (cmd.sum) begin
         n_ff <= nsum;
         d_ff <= p2_ff;
      end
      // Magnitudes and sign
      if (cmd.gcd_init) begin
         mn_ff  <= n_ff[32] ? 33'(-n_ff) : 33'(n_ff);
         md_ff  <= d_ff[31] ? 33'(-34'(d_ff)) : 33'(d_ff);
         x_ff   <= n_ff[32] ? 33'(-n_ff) : 33'(n_ff);
         y_ff   <= d_ff[31] ? 33'(-34'(d_ff)) : 33'(d_ff);
         neg_ff <= n_ff[32] ^ d_ff[31];
      end
      // x mod y, one bit a cycle
      if (cmd.rem_init) begin
         r_ff   <= '0;
         q_ff   <= x_ff;
         cnt_ff <= '0;
      end
      if (cmd.rem_step) begin
         q_ff   <= {q_ff[31:0], 1'b0};
         r_ff   <= trial[33] ? {r_ff[31:0], q_ff[32]} : trial[32:0];
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.gcd_swap) begin
         x_ff <= y_ff;
         y_ff <= r_ff;
      end
      // Divide both magnitudes by the gcd in x
      if (cmd.div_init) begin
         rn_ff  <= '0;
         qn_ff  <= mn_ff;
         rd_ff  <= '0;
         qd_ff  <= md_ff;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         qn_ff  <= {qn_ff[31:0], !trial_n[33]};
         rn_ff  <= trial_n[33] ? {rn_ff[31:0], qn_ff[32]} : trial_n[32:0];
         qd_ff  <= {qd_ff[31:0], !trial_d[33]};
         rd_ff  <= trial_d[33] ? {rd_ff[31:0], qd_ff[32]} : trial_d[32:0];
         cnt_ff <= cnt_ff + 6'd1;
      end
      // Build result, special cases first
      if (cmd.finish) begin
         if (n_ff == '0 && d_ff == '0) begin
            rsp_ff <= '{res_num: '0, res_den: '0, invalid: 1'b1};
         end else if (d_ff == '0) begin
            rsp_ff <= '{res_num: 32'sd1, res_den: '0, invalid: 1'b0};
         end else if (n_ff == '0) begin
            rsp_ff <= '{res_num: '0, res_den: 30'd1, invalid: 1'b0};
         end else begin
            rsp_ff.res_num <= neg_ff ? -qn_ff[31:0] : qn_ff[31:0];
            rsp_ff.res_den <= qd_ff[29:0];
            rsp_ff.invalid <= 1'b0;
         end
      end
      if (reset) cnt_ff <= '0;
   end

   // One pass covers all 33 dividend bits
   assign sts.special = (n_ff == '0) || (d_ff == '0);
   assign sts.y_zero  = (y_ff == '0);
   assign sts.last    = (cnt_ff == 6'd33);
   assign rsp         = rsp_ff;
endmodule

// ===== rtl/rau_control.sv =====
// Controller state machine sequencing the datapath.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  rau_pkg::sts_type sts,
   output rau_pkg::cmd_type cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_PROD, S_SUM, S_INIT, S_CHK, S_REM, S_SWAP, S_DINIT, S_DIV, S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      finish;

   assign finish = (state_ff == S_FIN);
   // Accept when idle and the output slot is free or leaving now
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.load = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin cmd.prod = 1'b1; state_in = S_SUM; end
         S_SUM:  begin cmd.sum = 1'b1; state_in = S_INIT; end
         S_INIT: begin
            cmd.gcd_init = 1'b1;
            state_in = sts.special ? S_FIN : S_CHK;
         end
         S_CHK: if (sts.y_zero) state_in = S_DINIT;
                else begin cmd.rem_init = 1'b1; state_in = S_REM; end
         S_REM: if (sts.last) state_in = S_SWAP;
                else cmd.rem_step = 1'b1;
         S_SWAP:  begin cmd.gcd_swap = 1'b1; state_in = S_CHK; end
         S_DINIT: begin cmd.div_init = 1'b1; state_in = S_DIV; end
         S_DIV: if (sts.last) state_in = S_FIN;
                else cmd.div_step = 1'b1;
         S_FIN: begin
            cmd.finish = 1'b1;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (finish && rsp_valid_ff && !rsp_ready) cmd.finish = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: two fractions in, one reduced fraction out per
// request. The bit-serial remainder unit (one quotient bit a cycle over 33
// bits) sets the time from acceptance to result, which grows with each Euclid
// step; zero, infinite or invalid results skip it. One request is processed
// at a time; a finished result is held until taken.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rau_pkg::rsp_type rsp_data
);
   rau_pkg::cmd_type cmd;
   rau_pkg::sts_type sts;

   rau_control u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   rau_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp(rsp_data)
   );

   `RAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `RAU_ASSERT_IMPL(a_inv_zero, clock, reset, rsp_valid && rsp_data.invalid, rsp_data.res_den == '0, "invalid with nonzero denominator")
endmodule

// ===== bench/rational_arithmetic_unit_tb.sv =====
// Testbench for the rational arithmetic unit: directed and random fraction requests,
// checked field by field against a built-in predictor. Depends on rau_pkg and the RTL.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rau_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rau_pkg::rsp_type rsp_data;

   rau_pkg::rsp_type fraction_q[$];
   int      mismatch_count;
   int      checked_count;
   int      sent_count;
   int      idle_cycles;
   bit      hold_rsp;
   bit      timed_out;

   localparam int IDLE_LIMIT = 20000;

   rational_arithmetic_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Reduce one request to its expected fraction
   function automatic rau_pkg::rsp_type reduce_fraction(rau_pkg::req_type r);
      longint an, ad, bn, bd, n, d;
      longint unsigned mn, md, x, y, t;
      rau_pkg::rsp_type o;
      an = r.a_num;
      ad = r.a_den;
      bn = r.b_num;
      bd = r.b_den;
      case (r.action)
         rau_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
         rau_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
         rau_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
         default: begin n = an * bd; d = ad * bn; end
      endcase
      o = '0;
      if (n == 0 && d == 0) begin
         o.invalid = 1'b1;
      end else if (d == 0) begin
         o.res_num = 32'sd1;
      end else if (n == 0) begin
         o.res_den = 30'd1;
      end else begin
         mn = (n < 0) ? -n : n;
         md = (d < 0) ? -d : d;
         x = mn;
         y = md;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         mn = mn / x;
         md = md / x;
         o.res_num = 32'(((n < 0) != (d < 0)) ? -mn : mn);
         o.res_den = 30'(md);
      end
      return o;
   endfunction

   // Offer one request and hold it until accepted
   task automatic send_request(logic [1:0] op, logic [15:0] an, logic [15:0] ad,
                               logic [15:0] bn, logic [15:0] bd);
      rau_pkg::req_type r;
      r.action = op;
      r.a_num = an;
      r.a_den = ad;
      r.b_num = bn;
      r.b_den = bd;
      req_data = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      fraction_q.push_back(reduce_fraction(r));
      sent_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Random gap between bursts
   task automatic sender_gap();
      int g;
      g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 120) : 0;
      repeat (g) @(negedge clock);
   endtask

   task automatic drain();
      while (fraction_q.size() != 0 && !timed_out) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 16'(int'($urandom_range(0, 4)) - 2);
         1: return 16'h8000;
         2: return 16'h7fff;
         3: return 16'(int'($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [15:0] ext[6];
      ext = '{16'h7fff, 16'h8001, 16'h8000, 16'h0000, 16'h0001, 16'hffff};
      for (int op = 0; op < 4; op++) begin
         send_request(op[1:0], 16'd1, 16'd2, 16'd1, 16'd3);
      end
      // zero over zero, nonzero over zero, zero numerator
      send_request(rau_pkg::OP_ADD, 16'd5, 16'd0, 16'd3, 16'd0);
      send_request(rau_pkg::OP_DIV, 16'd5, 16'd7, 16'd0, 16'd3);
      send_request(rau_pkg::OP_MUL, 16'd0, 16'd7, 16'd4, 16'd3);
      send_request(rau_pkg::OP_DIV, 16'd0, 16'd7, 16'd0, 16'd3);
      send_request(rau_pkg::OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4);
      for (int i = 0; i < 6; i++) begin
         send_request(i[1:0], ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6],
                      ext[(i + 3) % 6]);
      end
      send_request(rau_pkg::OP_MUL, 16'h7fff, 16'h8001, 16'h7fff, 16'h8001);
      send_request(rau_pkg::OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(rau_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_request(rau_pkg::OP_SUB, 16'h7fff, 16'h0001, 16'h8001, 16'h0001);
      send_request(rau_pkg::OP_DIV, 16'h0001, 16'h7fff, 16'h7fff, 16'h0001);
      drain();
   endtask

   task automatic test_random(int count);
      int burst;
      while (count > 0 && !timed_out) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && count > 0; i++) begin
            send_request(2'($urandom_range(0, 3)), rand_field(), rand_field(),
                         rand_field(), rand_field());
            count--;
         end
         sender_gap();
      end
   endtask

   // Receiver holds off long while the sender keeps offering
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++) begin
         send_request(2'($urandom_range(0, 3)), 16'd0, 16'($urandom_range(1, 9)),
                      16'($urandom), 16'($urandom_range(1, 9)));
      end
      drain();
   endtask

   // Receiver stall pattern, plus one long hold-off on request
   initial begin
      int hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            hold = 0;
            while (hold < 600) begin
               @(negedge clock);
               hold++;
            end
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 7) < 5);
         end
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      rau_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (fraction_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            e = fraction_q.pop_front();
            checked_count++;
            if (rsp_data.res_num !== e.res_num || rsp_data.res_den !== e.res_den ||
                rsp_data.invalid !== e.invalid) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected %0d/%0d inv %0b, got %0d/%0d inv %0b",
                           e.res_num, e.res_den, e.invalid,
                           rsp_data.res_num, rsp_data.res_den, rsp_data.invalid);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            timed_out = 1'b1;
            $display("watchdog expired, %0d results outstanding", fraction_q.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hold_rsp = 1'b0;
      timed_out = 1'b0;
      mismatch_count = 0;
      checked_count = 0;
      sent_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_random(200);
      // pause until everything has come back
      drain();
      test_random(200);
      drain();
      repeat (200) @(negedge clock);
      if (fraction_q.size() != 0) mismatch_count++;
      $display("sent %0d requests, checked %0d results over all four operations",
               sent_count, checked_count);
      $display("covered zero, infinite, invalid and extreme operands with stalls");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
